// ===== rtl/pcr_pkg.sv =====
// Shared types and constants for the pausable countdown reminder.
package pcr_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 3;

  localparam logic [AddrW-1:0] RegIntervalAddr = AddrW'(0);

  typedef enum logic [2:0] {
    ModeDisabled = 3'd0,
    ModeWaiting  = 3'd1,
    ModeCounting = 3'd2,
    ModeAway     = 3'd3,
    ModeAlerted  = 3'd4,
    ModeSnoozed  = 3'd5,
    ModeToday    = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    OpInit       = 3'd0,
    OpTick       = 3'd1,
    OpDrink      = 3'd2,
    OpSnooze     = 3'd3,
    OpSetPaused  = 3'd4,
    OpSetEnabled = 3'd5,
    OpApply      = 3'd6,
    OpConsume    = 3'd7
  } opcode_e;

  typedef struct packed {
    logic [2:0]       opcode;
    logic [DataW-1:0] now_ms;
    logic             cup_present;
    logic             flag_value;
    logic [DataW-1:0] snooze_ms;
  } in_t;

  typedef struct packed {
    logic [2:0]       mode;
    logic [DataW-1:0] time_left;
    logic             alert_flag;
  } out_t;

  typedef struct packed {
    mode_e            mode;
    logic             enabled;
    logic             paused_day;
    logic [DataW-1:0] remaining;
    logic [DataW-1:0] last_stamp;
    logic             snoozing;
    logic             alert_pending;
  } state_t;

endpackage

// ===== rtl/pausable_countdown_reminder_top.sv =====
// Top level of the pausable countdown reminder: handshake stages, state and register port.
// Each transaction is captured in an input register, evaluated against the reminder state by
// the combinational pcr_step logic, and its result lands in an output register; the state
// updates as the result is written, which also raises out_valid_o. While out_ready_i stays
// high a new transaction can be accepted every cycle. When a result waits for out_ready_i,
// one more transaction is taken into the input register and in_ready_o then stays low until
// the waiting result leaves. The interval register sits at byte address 0 of the APB port;
// write it only while no transaction is in flight. Elapsed time is taken modulo 2^32 from the
// now_ms timestamps.
module pausable_countdown_reminder_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  pcr_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output pcr_pkg::out_t             out_data_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pcr_pkg::AddrW-1:0] paddr,
  input  logic [pcr_pkg::DataW-1:0] pwdata,
  output logic [pcr_pkg::DataW-1:0] prdata,
  output logic                      pready
);

  pcr_pkg::in_t              in_q;
  logic                      in_valid_q;
  pcr_pkg::out_t             out_q;
  pcr_pkg::out_t             out_d;
  logic                      out_valid_q;
  pcr_pkg::state_t           state_q;
  pcr_pkg::state_t           state_d;
  logic [pcr_pkg::DataW-1:0] interval_q;
  logic                      advance;
  logic                      reg_sel;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign reg_sel    = (paddr[pcr_pkg::AddrW-1:2] == pcr_pkg::RegIntervalAddr[pcr_pkg::AddrW-1:2]);

  pcr_step u_step (
    .in_i      (in_q),
    .state_i   (state_q),
    .interval_i(interval_q),
    .state_o   (state_d),
    .out_o     (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      interval_q  <= '0;
      state_q     <= '{mode: pcr_pkg::ModeDisabled, default: '0};
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (psel && penable && pwrite && reg_sel) begin
        interval_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = reg_sel ? interval_q : '0;

endmodule

// ===== rtl/pcr_step.sv =====
// Next-state and result logic for one reminder transaction.
module pcr_step (
  input  pcr_pkg::in_t              in_i,
  input  pcr_pkg::state_t           state_i,
  input  logic [pcr_pkg::DataW-1:0] interval_i,
  output pcr_pkg::state_t           state_o,
  output pcr_pkg::out_t             out_o
);

  logic [pcr_pkg::DataW-1:0] elapsed;
  logic [pcr_pkg::DataW-1:0] diff;
  logic                      expired;
  logic                      active;
  logic                      stamp_upd;
  logic                      alert_out;
  pcr_pkg::state_t           st;

  function automatic pcr_pkg::state_t begin_count(
    input pcr_pkg::state_t           s,
    input logic [pcr_pkg::DataW-1:0] dur,
    input logic [pcr_pkg::DataW-1:0] now,
    input logic                      cup,
    input logic                      snz
  );
    pcr_pkg::state_t r;
    r               = s;
    r.remaining     = dur;
    r.last_stamp    = now;
    r.snoozing      = snz;
    r.alert_pending = 1'b0;
    if (!cup) begin
      r.mode = pcr_pkg::ModeAway;
    end else if (snz) begin
      r.mode = pcr_pkg::ModeSnoozed;
    end else begin
      r.mode = pcr_pkg::ModeCounting;
    end
    return r;
  endfunction

  assign elapsed = in_i.now_ms - state_i.last_stamp;
  assign diff    = state_i.remaining - elapsed;
  assign expired = (elapsed >= state_i.remaining);
  assign active  = state_i.enabled && (interval_i != '0);

  always_comb begin
    st        = state_i;
    stamp_upd = 1'b0;
    case (pcr_pkg::opcode_e'(in_i.opcode))
      pcr_pkg::OpInit: begin
        st.enabled       = in_i.flag_value;
        st.paused_day    = 1'b0;
        st.remaining     = interval_i;
        st.last_stamp    = in_i.now_ms;
        st.snoozing      = 1'b0;
        st.alert_pending = 1'b0;
        st.mode          = (in_i.flag_value && (interval_i != '0)) ?
                           pcr_pkg::ModeWaiting : pcr_pkg::ModeDisabled;
        stamp_upd        = 1'b1;
      end
      pcr_pkg::OpTick: begin
        if (active && state_i.mode != pcr_pkg::ModeDisabled &&
            state_i.mode != pcr_pkg::ModeToday &&
            state_i.mode != pcr_pkg::ModeAlerted) begin
          if (state_i.mode == pcr_pkg::ModeWaiting) begin
            if (in_i.cup_present) begin
              st        = begin_count(state_i, interval_i, in_i.now_ms, 1'b1, 1'b0);
              stamp_upd = 1'b1;
            end
          end else if (state_i.mode == pcr_pkg::ModeAway) begin
            if (in_i.cup_present) begin
              st.last_stamp = in_i.now_ms;
              st.mode       = state_i.snoozing ? pcr_pkg::ModeSnoozed :
                                                 pcr_pkg::ModeCounting;
              stamp_upd     = 1'b1;
            end
          end else begin
            st.last_stamp = in_i.now_ms;
            stamp_upd     = 1'b1;
            if (!in_i.cup_present) begin
              st.remaining = expired ? pcr_pkg::DataW'(1) : diff;
              st.mode      = pcr_pkg::ModeAway;
            end else if (expired) begin
              st.remaining     = '0;
              st.mode          = pcr_pkg::ModeAlerted;
              st.snoozing      = 1'b0;
              st.alert_pending = 1'b1;
            end else begin
              st.remaining = diff;
            end
          end
        end
      end
      pcr_pkg::OpDrink: begin
        if (active && !state_i.paused_day) begin
          st        = begin_count(state_i, interval_i, in_i.now_ms, in_i.cup_present, 1'b0);
          stamp_upd = 1'b1;
        end
      end
      pcr_pkg::OpSnooze: begin
        if (active && (in_i.snooze_ms != '0) && !state_i.paused_day) begin
          st        = begin_count(state_i, in_i.snooze_ms, in_i.now_ms,
                                  in_i.cup_present, 1'b1);
          stamp_upd = 1'b1;
        end
      end
      pcr_pkg::OpSetPaused: begin
        if (in_i.flag_value) begin
          st.mode          = active ? pcr_pkg::ModeToday : pcr_pkg::ModeDisabled;
          st.alert_pending = 1'b0;
          st.last_stamp    = in_i.now_ms;
          stamp_upd        = 1'b1;
        end else if (active) begin
          st        = begin_count(state_i, interval_i, in_i.now_ms, in_i.cup_present, 1'b0);
          stamp_upd = 1'b1;
        end
        st.paused_day = in_i.flag_value;
      end
      pcr_pkg::OpSetEnabled: begin
        st.enabled       = in_i.flag_value;
        st.last_stamp    = in_i.now_ms;
        st.alert_pending = 1'b0;
        st.snoozing      = 1'b0;
        st.remaining     = interval_i;
        stamp_upd        = 1'b1;
        if (!in_i.flag_value || (interval_i == '0)) begin
          st.mode = pcr_pkg::ModeDisabled;
        end else begin
          st.mode = state_i.paused_day ? pcr_pkg::ModeToday : pcr_pkg::ModeWaiting;
        end
      end
      pcr_pkg::OpApply: begin
        if (!active) begin
          st.mode          = pcr_pkg::ModeDisabled;
          st.remaining     = '0;
          st.alert_pending = 1'b0;
        end else if (state_i.paused_day) begin
          st.mode       = pcr_pkg::ModeToday;
          st.remaining  = interval_i;
          st.last_stamp = in_i.now_ms;
          stamp_upd     = 1'b1;
        end else begin
          st        = begin_count(state_i, interval_i, in_i.now_ms, in_i.cup_present, 1'b0);
          stamp_upd = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    alert_out = st.alert_pending;
    state_o   = st;
    if (pcr_pkg::opcode_e'(in_i.opcode) == pcr_pkg::OpConsume) begin
      state_o.alert_pending = 1'b0;
    end
  end

  always_comb begin
    out_o.mode       = 3'(st.mode);
    out_o.alert_flag = alert_out;
    case (st.mode)
      pcr_pkg::ModeAway: begin
        out_o.time_left = st.remaining;
      end
      pcr_pkg::ModeCounting, pcr_pkg::ModeSnoozed: begin
        if (stamp_upd) begin
          out_o.time_left = st.remaining;
        end else begin
          out_o.time_left = expired ? '0 : diff;
        end
      end
      default: begin
        out_o.time_left = '0;
      end
    endcase
  end

endmodule
